// ----- design/nulsf_pkg.sv -----
// Package for the NUL-terminated string finder.
// Holds shared types, character codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package nulsf_pkg;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] PRINT_LOW  = 8'h20;
   localparam logic [7:0] PRINT_HIGH = 8'h7E;

   localparam int unsigned CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDE_MODE   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUFFER_BASE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_LENGTH  = 2'd2;

   localparam logic [7:0] MIN_LENGTH_RESET = 8'd4;

   typedef struct packed {
      logic        wide_mode;
      logic [63:0] buffer_base;
      logic [7:0]  min_length;
   } nulsf_cfg_type;

   typedef struct packed {
      logic [63:0] string_address;
      logic [15:0] char_count;
      logic        count_saturated;
   } nulsf_result_type;

   function automatic logic is_print(input logic [7:0] b);
      return (b >= PRINT_LOW) && (b <= PRINT_HIGH);
   endfunction

   function automatic logic is_text_ctrl(input logic [7:0] b);
      logic hit;
      case (b) inside
         CHAR_TAB, CHAR_LF, CHAR_CR: hit = 1'b1;
         default:                    hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

// ----- design/nulsf_scan.sv -----
// Scanner core of the NUL-terminated string finder: run tracking per byte.
// Holds phase, pending byte, run start, run count and byte position.
// Depends on nulsf_pkg.
`timescale 1ns / 1ps

module nulsf_scan
   import nulsf_pkg::*;
#(
   parameter int unsigned COUNT_BITS  = 16,
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_fire,
   input  logic [7:0]       data_byte,
   input  logic             last_byte,
   input  logic             mode_clear,
   input  nulsf_cfg_type    cfg,
   output logic             hit,
   output nulsf_result_type result
);

   localparam int unsigned CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
   localparam int unsigned EXT_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
   localparam logic [OFFSET_BITS-1:0] POS_ONE = OFFSET_BITS'(1);

   typedef enum logic {
      PH_SEARCH,
      PH_RUN
   } phase_type;

   phase_type              phase_ff,  phase_in;
   logic [7:0]             held_ff,   held_in;
   logic                   held_valid_ff, held_valid_in;
   logic [OFFSET_BITS-1:0] start_ff,  start_in;
   logic [COUNT_BITS-1:0]  count_ff,  count_in;
   logic [OFFSET_BITS-1:0] pos_ff,    pos_in;

   logic                   finish;
   logic                   saturated;
   logic [COUNT_BITS-1:0]  count_bump;
   logic [EXT_W-1:0]       count_ext;

   assign saturated  = (count_ff == CNT_MAX);
   assign count_bump = saturated ? count_ff : count_ff + CNT_ONE;
   assign count_ext  = EXT_W'(count_ff);

   always_comb begin
      phase_in      = phase_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      finish        = 1'b0;
      if (mode_clear) begin
         phase_in      = PH_SEARCH;
         held_in       = CHAR_NUL;
         held_valid_in = 1'b0;
      end else if (byte_fire) begin
         if (!cfg.wide_mode) begin
            if (phase_ff != PH_RUN) begin
               if (is_print(data_byte)) begin
                  phase_in = PH_RUN;
                  start_in = pos_ff;
                  count_in = CNT_ONE;
               end
            end else if (data_byte == CHAR_NUL) begin
               finish   = 1'b1;
               phase_in = PH_SEARCH;
            end else if (is_print(data_byte) || is_text_ctrl(data_byte)) begin
               count_in = count_bump;
            end else begin
               phase_in = PH_SEARCH;
            end
         end else if (!held_valid_ff) begin
            held_in       = data_byte;
            held_valid_in = 1'b1;
         end else if (phase_ff != PH_RUN) begin
            if (is_print(held_ff) && data_byte == CHAR_NUL) begin
               phase_in      = PH_RUN;
               start_in      = pos_ff - POS_ONE;
               count_in      = CNT_ONE;
               held_valid_in = 1'b0;
            end else begin
               held_in = data_byte;
            end
         end else begin
            held_valid_in = 1'b0;
            if (is_print(held_ff) && data_byte == CHAR_NUL) begin
               count_in = count_bump;
            end else if (held_ff == CHAR_NUL && data_byte == CHAR_NUL) begin
               finish   = 1'b1;
               phase_in = PH_SEARCH;
            end else begin
               phase_in = PH_SEARCH;
            end
         end
         if (last_byte) begin
            phase_in      = PH_SEARCH;
            held_valid_in = 1'b0;
            pos_in        = '0;
         end else begin
            pos_in = pos_ff + POS_ONE;
         end
      end
   end

   assign hit = finish && ((CMP_W'(count_ff) >= CMP_W'(cfg.min_length)) || saturated);
   assign result.string_address  = cfg.buffer_base + 64'(start_ff);
   assign result.char_count      = count_ext[15:0];
   assign result.count_saturated = saturated;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SEARCH;
         held_ff       <= CHAR_NUL;
         held_valid_ff <= 1'b0;
         start_ff      <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         start_ff      <= start_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
      end
   end

endmodule

// ----- design/nul_terminated_string_finder_top.sv -----
// Top level of the NUL-terminated string finder (ASCII and UTF-16LE).
// Holds the register file and a two-entry result buffer; instantiates nulsf_scan.
// Depends on nulsf_pkg and nulsf_scan.
//
//   channel  direction  handshake        payload
//   req      in         valid / stall    data_byte, last_byte
//   rsp      out        valid / stall    string_address, char_count, count_saturated
//   csr      in         valid / ready    index, wdata (wide_mode, buffer_base, min_length)
//
// One byte per cycle while req_stall is low; a result is registered in the result buffer before it appears on rsp.
// The scanner state updates in the transfer cycle; the result register is the only stage.
// Synchronous active-high reset; all registers but the result data return to reset values, no clearing pass.
// rsp stall fills the skid entry; req stalls only while both result entries are held.
`timescale 1ns / 1ps

module nul_terminated_string_finder_top
   import nulsf_pkg::*;
#(
   parameter int unsigned COUNT_BITS  = 16,
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_last_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [63:0]               rsp_string_address,
   output logic [15:0]               rsp_char_count,
   output logic                      rsp_count_saturated,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]               csr_wdata
);

   nulsf_cfg_type    cfg_ff, cfg_in;
   logic             csr_fire;
   logic             mode_clear;
   logic             req_fire;
   logic             rsp_fire;
   logic             scan_hit;
   nulsf_result_type scan_result;

   nulsf_result_type out_ff, out_in;
   logic             out_valid_ff, out_valid_in;
   nulsf_result_type skid_ff, skid_in;
   logic             skid_valid_ff, skid_valid_in;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign mode_clear = csr_fire && (csr_index == CSR_WIDE_MODE);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_WIDE_MODE:   cfg_in.wide_mode   = csr_wdata[0];
            CSR_BUFFER_BASE: cfg_in.buffer_base = csr_wdata;
            CSR_MIN_LENGTH:  cfg_in.min_length  = csr_wdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wide_mode   <= 1'b0;
         cfg_ff.buffer_base <= '0;
         cfg_ff.min_length  <= MIN_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;

   nulsf_scan #(
      .COUNT_BITS  (COUNT_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .byte_fire  (req_fire),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .mode_clear (mode_clear),
      .cfg        (cfg_ff),
      .hit        (scan_hit),
      .result     (scan_result)
   );

   assign rsp_fire = out_valid_ff && !rsp_stall;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_fire) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = scan_result;
            out_valid_in = req_fire && scan_hit;
         end
      end else if (req_fire && scan_hit) begin
         if (!out_valid_ff) begin
            out_in       = scan_result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = scan_result;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_string_address  = out_ff.string_address;
   assign rsp_char_count      = out_ff.char_count;
   assign rsp_count_saturated = out_ff.count_saturated;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_hit_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && scan_hit) |=> rsp_valid)
      else $error("found string did not reach the result port");

   a_stall_keeps_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && req_fire && scan_hit) |=> skid_valid_ff)
      else $error("result lost while output stalled");

endmodule
